FILE: rtl/core/cbcr_pkg.sv
`default_nettype none

package cbcr_pkg;

  // Restitution register
  localparam int unsigned REST_W     = 17;
  localparam logic [REST_W-1:0] REST_RESET = 17'd39322;

  // Contact codes
  localparam logic [1:0] CONTACT_NONE    = 2'd0;
  localparam logic [1:0] CONTACT_SEP     = 2'd1;
  localparam logic [1:0] CONTACT_IMPULSE = 2'd2;

  // Pipeline layout
  localparam int unsigned SQRT_BITS     = 32;
  localparam int unsigned SQRT_PER_STG  = 2;
  localparam int unsigned SQRT_STAGES   = SQRT_BITS / SQRT_PER_STG;
  localparam int unsigned DIV_STEPS     = 17;
  localparam int unsigned DIV_PER_STG   = 2;
  localparam int unsigned DIV_STAGES    = (DIV_STEPS + DIV_PER_STG - 1) / DIV_PER_STG;
  localparam int unsigned ST_IN         = 0;
  localparam int unsigned ST_DELTA      = 1;
  localparam int unsigned ST_SQUARE     = 2;
  localparam int unsigned ST_HIT        = 3;
  localparam int unsigned ST_SQRT0      = 4;
  localparam int unsigned ST_DIV0       = ST_SQRT0 + SQRT_STAGES;
  localparam int unsigned ST_NORM       = ST_DIV0 + DIV_STAGES;
  localparam int unsigned ST_PROD       = ST_NORM + 1;
  localparam int unsigned ST_POS        = ST_NORM + 2;
  localparam int unsigned ST_IMP        = ST_NORM + 3;
  localparam int unsigned ST_JVEC       = ST_NORM + 4;
  localparam int unsigned ST_VEL        = ST_NORM + 5;
  localparam int unsigned NUM_STAGES    = ST_VEL + 1;

  // Saturation bounds
  localparam logic signed [47:0] SAT_MAX = 48'sd2147483647;
  localparam logic signed [47:0] SAT_MIN = -48'sd2147483648;

  typedef struct packed {
    logic signed [31:0] circle_x;
    logic signed [31:0] circle_y;
    logic signed [31:0] circle_vx;
    logic signed [31:0] circle_vy;
    logic [15:0]        radius;
    logic signed [31:0] box_x;
    logic signed [31:0] box_y;
    logic signed [31:0] box_vx;
    logic signed [31:0] box_vy;
    logic [30:0]        box_half;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_circle_x;
    logic signed [31:0] new_circle_y;
    logic signed [31:0] new_circle_vx;
    logic signed [31:0] new_circle_vy;
    logic signed [31:0] new_box_x;
    logic signed [31:0] new_box_y;
    logic signed [31:0] new_box_vx;
    logic signed [31:0] new_box_vy;
    logic [1:0]         contact;
  } out_item_t;

  // Everything one item carries down the pipeline
  typedef struct packed {
    in_item_t           item;
    logic signed [34:0] dx;
    logic signed [34:0] dy;
    logic [33:0]        ax;
    logic [33:0]        ay;
    logic               ltx;
    logic               lty;
    logic [63:0]        sqa;
    logic [63:0]        sqb;
    logic [63:0]        rq2;
    logic               hit;
    logic [63:0]        sq_x;
    logic [34:0]        sq_rem;
    logic [31:0]        root;
    logic [32:0]        rem_x;
    logic [32:0]        rem_y;
    logic [16:0]        qx;
    logic [16:0]        qy;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [33:0] pen;
    logic signed [32:0] rvx;
    logic signed [32:0] rvy;
    logic signed [51:0] mxp;
    logic signed [51:0] myp;
    logic signed [50:0] pvx;
    logic signed [50:0] pvy;
    logic signed [35:0] van;
    logic               approach;
    logic signed [55:0] jp;
    logic signed [56:0] jxp;
    logic signed [56:0] jyp;
    logic [1:0]         contact;
  } pipe_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'sh7FFF_FFFF;
    else if (v < SAT_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cbcr_pipe_ctl.sv
`default_nettype none

module cbcr_pipe_ctl #(
  parameter int unsigned DEPTH = cbcr_pkg::NUM_STAGES
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  input  wire              out_stall,
  output logic [DEPTH-1:0] ld,
  output logic [DEPTH-1:0] vld
);
  import cbcr_pkg::*;

  localparam int unsigned LAST = DEPTH - 1;

  logic [DEPTH-1:0] vld_r;

  // Load a stage when it is empty or its successor moves on
  always_comb begin
    ld[LAST] = !vld_r[LAST] || !out_stall;
    for (int k = LAST - 1; k >= 0; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
  end

  // Advance valid bits alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < DEPTH; k++) begin
        if (ld[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign vld = vld_r;

  // Occupancy tracks accepted minus delivered transactions
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && ld[0] && !(vld_r[LAST] && !out_stall)) |=>
      ($countones(vld_r) == $past($countones(vld_r)) + 1))
    else $error("pipeline occupancy did not grow on accept");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_valid && ld[0]) && vld_r[LAST] && !out_stall) |=>
      ($countones(vld_r) + 1 == $past($countones(vld_r))))
    else $error("pipeline occupancy did not shrink on delivery");

  a_even: assert property (@(posedge clk) disable iff (!rst_n)
    ((in_valid && ld[0]) == (vld_r[LAST] && !out_stall)) |=>
      ($countones(vld_r) == $past($countones(vld_r))))
    else $error("transaction lost or duplicated in pipeline");

endmodule

`default_nettype wire

FILE: rtl/core/circle_box_collision_resolve.sv
// Circle versus axis-aligned box contact resolver.
//
// Input channel (in_valid / in_stall / in_data): one circle and one box per
// transaction. Result channel (out_valid / out_stall / out_data): corrected
// positions and velocities plus a contact code, one result per input.
// Configuration channel (cfg_valid / cfg_ready / cfg_data): the restitution
// factor, unsigned Q1.16; cfg_ready is always high. Write it while idle.
//
// The datapath is a 35-stage pipeline: edge deltas, squares and overlap
// test, a 16-stage square root (two result bits per stage), a 9-stage
// normal divider (two quotient bits per stage), then multiply stages for
// separation and impulse. One transaction per cycle is sustained while the
// receiver does not stall.
//
// Reset clears all valid bits and loads restitution with 0.6. When the
// receiver stalls, the last stage holds its result and earlier stages keep
// filling empty slots; in_stall rises only once every stage is occupied.
`default_nettype none

module circle_box_collision_resolve (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  cbcr_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output cbcr_pkg::out_item_t  out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [cbcr_pkg::REST_W-1:0] cfg_data
);
  import cbcr_pkg::*;

  localparam int unsigned LAST = NUM_STAGES - 1;

  logic [REST_W-1:0]     rest_r;
  logic [NUM_STAGES-1:0] ld;
  logic [NUM_STAGES-1:0] vld;
  pipe_t                 stg_r   [NUM_STAGES];
  pipe_t                 stg_nxt [NUM_STAGES];

  // Two root bits per call, digit by digit
  function automatic pipe_t sqrt_step(input pipe_t p);
    pipe_t              q;
    logic [34:0]        rs;
    logic [34:0]        trial;
    q = p;
    for (int t = 0; t < SQRT_PER_STG; t++) begin
      rs    = {q.sq_rem[32:0], q.sq_x[63:62]};
      trial = {1'b0, q.root, 2'b01};
      if (rs >= trial) begin
        q.sq_rem = rs - trial;
        q.root   = {q.root[30:0], 1'b1};
      end else begin
        q.sq_rem = rs;
        q.root   = {q.root[30:0], 1'b0};
      end
      q.sq_x = {q.sq_x[61:0], 2'b00};
    end
    return q;
  endfunction

  // Two quotient bits per call for both normal components
  function automatic pipe_t div_step(input pipe_t p, input int g);
    pipe_t       q;
    int          s;
    logic [32:0] rs;
    logic [32:0] dv;
    q  = p;
    dv = {1'b0, p.root};
    for (int t = 0; t < DIV_PER_STG; t++) begin
      s = g * DIV_PER_STG + t;
      if (s < DIV_STEPS) begin
        rs = {q.rem_x[31:0], (s == 0) ? q.ax[0] : 1'b0};
        if (rs >= dv) begin
          q.rem_x = rs - dv;
          q.qx    = {q.qx[15:0], 1'b1};
        end else begin
          q.rem_x = rs;
          q.qx    = {q.qx[15:0], 1'b0};
        end
        rs = {q.rem_y[31:0], (s == 0) ? q.ay[0] : 1'b0};
        if (rs >= dv) begin
          q.rem_y = rs - dv;
          q.qy    = {q.qy[15:0], 1'b1};
        end else begin
          q.rem_y = rs;
          q.qy    = {q.qy[15:0], 1'b0};
        end
      end
    end
    return q;
  endfunction

  // Pipeline flow control
  cbcr_pipe_ctl #(
    .DEPTH (NUM_STAGES)
  ) u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .ld        (ld),
    .vld       (vld)
  );

  assign in_stall  = !ld[0];
  assign out_valid = vld[LAST];
  assign cfg_ready = 1'b1;

  // Restitution register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r <= REST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rest_r <= cfg_data;
    end
  end

  // Stage logic
  always_comb begin
    pipe_t              p;
    logic signed [33:0] cxe, cye, lo, hi, cl;
    logic signed [34:0] mx, my;
    logic signed [51:0] vs;
    logic signed [36:0] negvan;
    logic signed [18:0] factor;
    logic signed [38:0] j;
    logic signed [40:0] jx, jy;
    logic [31:0]        rqv;

    // Capture
    p      = '0;
    p.item = in_data;
    stg_nxt[ST_IN] = p;

    // Closest point deltas
    p   = stg_r[ST_IN];
    cxe = 34'(p.item.circle_x);
    cye = 34'(p.item.circle_y);
    lo  = 34'(p.item.box_x) - $signed({3'b000, p.item.box_half});
    hi  = 34'(p.item.box_x) + $signed({3'b000, p.item.box_half});
    cl  = (cxe < lo) ? lo : ((cxe > hi) ? hi : cxe);
    p.dx = 35'(cxe) - 35'(cl);
    lo  = 34'(p.item.box_y) - $signed({3'b000, p.item.box_half});
    hi  = 34'(p.item.box_y) + $signed({3'b000, p.item.box_half});
    cl  = (cye < lo) ? lo : ((cye > hi) ? hi : cye);
    p.dy = 35'(cye) - 35'(cl);
    p.ax = (p.dx < 0) ? 34'(-p.dx) : 34'(p.dx);
    p.ay = (p.dy < 0) ? 34'(-p.dy) : 34'(p.dy);
    stg_nxt[ST_DELTA] = p;

    // Squares against the radius
    p   = stg_r[ST_DELTA];
    rqv = {p.item.radius, 16'h0000};
    p.ltx = p.ax < {2'b00, rqv};
    p.lty = p.ay < {2'b00, rqv};
    p.sqa = p.ax[31:0] * p.ax[31:0];
    p.sqb = p.ay[31:0] * p.ay[31:0];
    p.rq2 = {32'(p.item.radius) * 32'(p.item.radius), 32'h0};
    stg_nxt[ST_SQUARE] = p;

    // Overlap test; seed the root
    p = stg_r[ST_SQUARE];
    p.hit    = p.ltx && p.lty && (p.sqa < p.rq2) && (p.sqb < p.rq2 - p.sqa);
    p.sq_x   = p.sqa + p.sqb;
    p.sq_rem = '0;
    p.root   = '0;
    stg_nxt[ST_HIT] = p;

    // Square root
    for (int k = 0; k < SQRT_STAGES; k++) begin
      stg_nxt[ST_SQRT0 + k] = sqrt_step(stg_r[ST_SQRT0 + k - 1]);
    end

    // Normal division; the leading remainder is the delta halved
    p = stg_r[ST_DIV0 - 1];
    p.rem_x = p.ax[33:1];
    p.rem_y = p.ay[33:1];
    p.qx    = '0;
    p.qy    = '0;
    stg_nxt[ST_DIV0] = div_step(p, 0);
    for (int g = 1; g < DIV_STAGES; g++) begin
      stg_nxt[ST_DIV0 + g] = div_step(stg_r[ST_DIV0 + g - 1], g);
    end

    // Signed normal, penetration, relative velocity
    p   = stg_r[ST_NORM - 1];
    rqv = {p.item.radius, 16'h0000};
    if (p.root == '0) begin
      p.nx = 18'sd0;
      p.ny = 18'sd65536;
    end else begin
      p.nx = (p.dx < 0) ? -$signed({1'b0, p.qx}) : $signed({1'b0, p.qx});
      p.ny = (p.dy < 0) ? -$signed({1'b0, p.qy}) : $signed({1'b0, p.qy});
    end
    p.pen = $signed({2'b00, rqv}) - $signed({2'b00, p.root});
    p.rvx = 33'(p.item.circle_vx) - 33'(p.item.box_vx);
    p.rvy = 33'(p.item.circle_vy) - 33'(p.item.box_vy);
    stg_nxt[ST_NORM] = p;

    // Products
    p = stg_r[ST_NORM];
    p.mxp = p.nx * p.pen;
    p.myp = p.ny * p.pen;
    p.pvx = p.rvx * p.nx;
    p.pvy = p.rvy * p.ny;
    stg_nxt[ST_PROD] = p;

    // Separate positions; normal speed
    p  = stg_r[ST_PROD];
    mx = p.mxp[51:17];
    my = p.myp[51:17];
    vs = 52'(p.pvx) + 52'(p.pvy);
    p.van = vs[51:16];
    if (p.hit) begin
      p.item.circle_x = sat32(48'(p.item.circle_x) + 48'(mx));
      p.item.circle_y = sat32(48'(p.item.circle_y) + 48'(my));
      p.item.box_x    = sat32(48'(p.item.box_x) - 48'(mx));
      p.item.box_y    = sat32(48'(p.item.box_y) - 48'(my));
      p.contact       = CONTACT_SEP;
    end else begin
      p.contact       = CONTACT_NONE;
    end
    stg_nxt[ST_POS] = p;

    // Impulse magnitude
    p      = stg_r[ST_POS];
    p.approach = p.hit && (p.van <= 36'sd0);
    negvan = -37'(p.van);
    factor = $signed({1'b0, 18'(18'd65536 + {1'b0, rest_r})});
    p.jp   = negvan * factor;
    stg_nxt[ST_IMP] = p;

    // Impulse along the normal
    p     = stg_r[ST_IMP];
    j     = p.jp[55:17];
    p.jxp = j * p.nx;
    p.jyp = j * p.ny;
    stg_nxt[ST_JVEC] = p;

    // Apply velocity change
    p  = stg_r[ST_JVEC];
    jx = p.jxp[56:16];
    jy = p.jyp[56:16];
    if (p.approach) begin
      p.item.circle_vx = sat32(48'(p.item.circle_vx) + 48'(jx));
      p.item.circle_vy = sat32(48'(p.item.circle_vy) + 48'(jy));
      p.item.box_vx    = sat32(48'(p.item.box_vx) - 48'(jx));
      p.item.box_vy    = sat32(48'(p.item.box_vy) - 48'(jy));
      p.contact        = CONTACT_IMPULSE;
    end
    stg_nxt[ST_VEL] = p;
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (ld[k]) stg_r[k] <= stg_nxt[k];
    end
  end

  // Drive the result
  always_comb begin
    out_data.new_circle_x  = stg_r[LAST].item.circle_x;
    out_data.new_circle_y  = stg_r[LAST].item.circle_y;
    out_data.new_circle_vx = stg_r[LAST].item.circle_vx;
    out_data.new_circle_vy = stg_r[LAST].item.circle_vy;
    out_data.new_box_x     = stg_r[LAST].item.box_x;
    out_data.new_box_y     = stg_r[LAST].item.box_y;
    out_data.new_box_vx    = stg_r[LAST].item.box_vx;
    out_data.new_box_vy    = stg_r[LAST].item.box_vy;
    out_data.contact       = stg_r[LAST].contact;
  end

endmodule

`default_nettype wire

FILE: verif/circle_box_collision_resolve_test.sv
`timescale 1ns / 1ps

module circle_box_collision_resolve_test;
  import cbcr_pkg::*;

  localparam int IN_W = $bits(in_item_t);

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [REST_W-1:0]   cfg_data;

  logic [REST_W-1:0]   bounce;
  out_item_t           pending_q[$];
  int                  error_count;
  bit                  sink_quiet;
  int                  stall_left;

  circle_box_collision_resolve dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("circle_box_collision_resolve_test: errors");
    $finish;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [31:0] saturate(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Compute the resolved bodies for one circle/box pair
  function automatic out_item_t resolve_contact(in_item_t t);
    longint cx, cy, cvx, cvy, rq, bx, by, bvx, bvy, half;
    longint dx, dy, dlen, nx, ny, pen, mx, my, van, j, jx, jy;
    longint r[8];
    longint unsigned ax, ay, rq2, a, b, d2;
    logic [1:0] c;
    out_item_t o;
    cx = t.circle_x; cy = t.circle_y; cvx = t.circle_vx; cvy = t.circle_vy;
    rq = longint'(t.radius) << 16;
    bx = t.box_x; by = t.box_y; bvx = t.box_vx; bvy = t.box_vy;
    half = longint'(t.box_half);
    r[0] = cx; r[1] = cy; r[2] = cvx; r[3] = cvy;
    r[4] = bx; r[5] = by; r[6] = bvx; r[7] = bvy;
    c = CONTACT_NONE;
    dx = cx - clamp_range(cx, bx - half, bx + half);
    dy = cy - clamp_range(cy, by - half, by + half);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    rq2 = rq * rq;
    if (ax < rq && ay < rq) begin
      a = ax * ax;
      b = ay * ay;
      if (a < rq2 && b < rq2 - a) begin
        d2 = a + b;
        dlen = int_sqrt(d2);
        if (dlen > 0) begin
          nx = clamp_range((dx * 65536) / dlen, -65536, 65536);
          ny = clamp_range((dy * 65536) / dlen, -65536, 65536);
        end else begin
          nx = 0;
          ny = 65536;
        end
        pen = rq - dlen;
        mx = floor_shift(nx * pen, 17);
        my = floor_shift(ny * pen, 17);
        r[0] = cx + mx; r[1] = cy + my; r[4] = bx - mx; r[5] = by - my;
        c = CONTACT_SEP;
        van = floor_shift((cvx - bvx) * nx + (cvy - bvy) * ny, 16);
        if (van <= 0) begin
          j = floor_shift(-van * (65536 + longint'(bounce)), 17);
          jx = floor_shift(j * nx, 16);
          jy = floor_shift(j * ny, 16);
          r[2] = cvx + jx; r[3] = cvy + jy; r[6] = bvx - jx; r[7] = bvy - jy;
          c = CONTACT_IMPULSE;
        end
      end
    end
    o.new_circle_x = saturate(r[0]);
    o.new_circle_y = saturate(r[1]);
    o.new_circle_vx = saturate(r[2]);
    o.new_circle_vy = saturate(r[3]);
    o.new_box_x = saturate(r[4]);
    o.new_box_y = saturate(r[5]);
    o.new_box_vx = saturate(r[6]);
    o.new_box_vy = saturate(r[7]);
    o.contact = c;
    return o;
  endfunction

  // Random stall on the result side, mostly short runs, a few long; hold low when asked
  always @(posedge clk) begin
    if (!rst_n || sink_quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) < 7) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 2);
    end
  end

  // Compare every result transaction against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, out_data);
        error_count++;
      end else begin
        want = pending_q.pop_front();
        if (out_data !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, out_data);
          error_count++;
        end
      end
    end
  end

  // Drop valid only when a gap follows, so back-to-back sends keep it high
  task automatic idle_gap();
    int n;
    if ($urandom_range(0, 9) < 6) n = 0;
    else if ($urandom_range(0, 19) == 0) n = $urandom_range(10, 40);
    else n = $urandom_range(1, 3);
    if (n > 0) in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_pair(in_item_t t);
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_q.push_back(resolve_contact(t));
    idle_gap();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_bounce(logic [REST_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    bounce = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t base_pair();
    in_item_t t;
    t = '0;
    t.radius = 16'd4;
    t.box_half = 31'h0002_0000;
    return t;
  endfunction

  // Random pair near contact, occasionally with full-range noise
  function automatic in_item_t random_pair();
    in_item_t t;
    int sel;
    t = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom});
    sel = $urandom_range(0, 9);
    if (sel < 8) begin
      t.radius = (sel == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
      t.box_half = (sel == 1) ? 31'($urandom) : 31'($urandom_range(0, 32'h0040_0000));
      t.box_y = t.box_y >>> ($urandom_range(0, 1) ? 0 : 4);
      t.box_x = t.box_y;
      t.circle_x = t.box_x + $signed(32'($urandom_range(0, 32'h0080_0000))) - 32'h0040_0000;
      t.circle_y = t.box_y + $signed(32'($urandom_range(0, 32'h0080_0000))) - 32'h0040_0000;
      if (sel > 3) begin
        t.circle_vx = t.circle_vx >>> 8; t.circle_vy = t.circle_vy >>> 8;
        t.box_vx = t.box_vx >>> 8; t.box_vy = t.box_vy >>> 8;
      end
    end
    return t;
  endfunction

  task automatic test_directed();
    in_item_t t;
    // centre inside box, approaching and separating
    t = base_pair(); t.circle_vy = -32'sh10000; send_pair(t);
    t = base_pair(); t.circle_vy = 32'sh10000; send_pair(t);
    // radius zero never touches
    t = base_pair(); t.radius = 0; send_pair(t);
    // off the +x, -x and +y sides and a corner, overlapping
    t = base_pair(); t.circle_x = 32'sh0004_0000; t.circle_vx = -32'sh20000; send_pair(t);
    t = base_pair(); t.circle_x = -32'sh0004_0000; t.circle_vx = 32'sh20000; send_pair(t);
    t = base_pair(); t.circle_y = 32'sh0005_8000; send_pair(t);
    t = base_pair(); t.circle_x = 32'sh0003_0000; t.circle_y = 32'sh0003_0000;
    t.box_vx = 32'sh7FFF_FFFF; send_pair(t);
    // far apart
    t = base_pair(); t.circle_x = 32'sh7FFF_FFFF; send_pair(t);
    // extremes: saturation on positions and velocities
    t = base_pair(); t.radius = 16'hFFFF; t.circle_y = 32'sh7FFF_0000;
    t.box_y = 32'sh7FFF_0000; t.circle_vy = 32'sh8000_0000; t.box_vy = 32'sh7FFF_FFFF;
    send_pair(t);
    t = base_pair(); t.radius = 16'hFFFF; t.box_half = 31'h7FFF_FFFF;
    t.circle_x = 32'sh8000_0000; t.box_x = 32'sh8000_0000; t.box_y = 32'sh8000_0000;
    t.circle_y = 32'sh8000_0000; t.circle_vy = 32'sh8000_0000; send_pair(t);
    t = '1; send_pair(t);
    t = '0; send_pair(t);
    drain();
  endtask

  task automatic test_random(int count);
    repeat (count) send_pair(random_pair());
    drain();
  endtask

  task automatic test_backpressure_pause();
    repeat (20) send_pair(random_pair());
    // Pause the sender until every outstanding result has come back
    in_valid <= 1'b0;
    sink_quiet = 1'b1;
    while (pending_q.size() != 0) @(posedge clk);
    sink_quiet = 1'b0;
    repeat (20) send_pair(random_pair());
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    out_stall = 1'b0;
    sink_quiet = 1'b0;
    error_count = 0;
    bounce = REST_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(500);
    test_backpressure_pause();
    write_bounce('0);
    test_directed();
    test_random(400);
    write_bounce(17'h10000);
    test_random(400);
    write_bounce(17'h1FFFF);
    test_directed();
    test_random(300);
    write_bounce(17'($urandom));
    test_random(300);

    if (error_count == 0) begin
      $display("circle_box_collision_resolve_test: clean");
    end else begin
      $display("circle_box_collision_resolve_test: errors");
    end
    $finish;
  end

endmodule
